// File: rtl/core/stni_pkg.sv
package stni_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int VAL_W      = 32;
    localparam int RES_W      = 16;
    localparam int OUT_CNT_W  = 9;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int SCAN_LANES = 32;
    localparam int LANE_LVLS  = 5;
    localparam int POP_W      = LANE_LVLS + 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic eval;
        logic shift;
        logic ins_we;
    } cell_ctrl_t;

    // Per-cell result of one request, shifted down the row during the scan.
    typedef struct packed {
        logic             lt;
        logic             uniq;
        logic             sel;
        logic             left;
        logic [VAL_W-1:0] val;
    } cell_res_t;

    // Pairwise adder tree over one scan slice.
    function automatic logic [POP_W-1:0] popcount(input logic [SCAN_LANES-1:0] bits);
        logic [POP_W-1:0] cnt [SCAN_LANES];
        for (int k = 0; k < SCAN_LANES; k++) begin
            cnt[k] = POP_W'(bits[k]);
        end
        for (int lvl = 0; lvl < LANE_LVLS; lvl++) begin
            for (int k = 0; k < (SCAN_LANES >> (lvl + 1)); k++) begin
                cnt[k] = cnt[2*k] + cnt[2*k+1];
            end
        end
        return cnt[0];
    endfunction

endpackage

// File: rtl/core/stni_cell.sv
module stni_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stni_pkg::cell_ctrl_t        ctrl,
    input  logic [stni_pkg::VAL_W-1:0]  req_value,
    input  logic [stni_pkg::RES_W-1:0]  resolution,
    input  logic [stni_pkg::VAL_W-1:0]  prev_entry,
    input  logic                        prev_lt,
    input  logic                        prev_valid,
    input  logic                        has_left,
    input  logic                        next_valid,
    input  stni_pkg::cell_res_t         shift_in,
    output logic [stni_pkg::VAL_W-1:0]  entry,
    output logic                        valid,
    output logic                        lt,
    output stni_pkg::cell_res_t         res
);

    logic [stni_pkg::VAL_W-1:0] entry_reg, entry_next;
    logic                       valid_reg, valid_next;
    stni_pkg::cell_res_t        res_reg, res_next;
    stni_pkg::cell_res_t        local_res;

    logic boundary;
    logic go_left;
    logic at_end;

    always_comb begin
        lt       = valid_reg && (entry_reg < req_value);
        boundary = valid_reg && !lt && prev_lt;
        go_left  = boundary && has_left &&
                   ((req_value - prev_entry) < (entry_reg - req_value));
        at_end   = lt && !next_valid;

        local_res.lt   = lt;
        local_res.uniq = valid_reg && (!has_left ||
                         ((entry_reg - prev_entry) >
                          {{(stni_pkg::VAL_W-stni_pkg::RES_W){1'b0}}, resolution}));
        local_res.sel  = boundary || at_end;
        local_res.left = go_left || at_end;
        local_res.val  = go_left ? prev_entry : entry_reg;
    end

    // Insertion: cells at or above the insert point take their left
    // neighbor's entry, the first of them takes the new value.
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.ins_we && !lt) begin
            entry_next = prev_lt ? req_value : prev_entry;
            valid_next = prev_valid;
        end
    end

    always_comb begin
        res_next = res_reg;
        if (ctrl.eval) begin
            res_next = local_res;
        end else if (ctrl.shift) begin
            res_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        res_reg   <= res_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

// File: rtl/core/sorted_table_nearest_insert_core.sv
// Sorted distance table with nearest-value search. Requests arrive as beats
// on the s_ channel (s_tuser carries the kind: insert, find nearest or count
// unique groups; s_tdata carries the unsigned Q16.16 value) and each request
// gives exactly one result beat on the m_ channel. The table lives in a row
// of DEPTH cells, one entry per cell, kept in ascending order. In the cycle
// after a request is taken every cell compares its entry with the request
// value at once; an insert shifts the upper part of the row by one cell in
// that same cycle. The per-cell results are then shifted down the row and
// summed 32 cells per cycle. A finished result beat is held in its own
// output register, so the next request is accepted while that beat waits
// for m_tready. Inserts into a full table are dropped with a full status;
// a find on an empty table returns an empty status. The resolution register
// is written through cfg_wr_en and cfg_wr_data and resets to 1; the user
// must write it only while no request is in flight, and the block itself
// does not enforce this.
module sorted_table_nearest_insert_core #(
    parameter int DEPTH = stni_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] value
    input  logic [1:0]                     s_tuser,   // [1:0] kind
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [8:0] position, [40:9] nearest_value, [42:41] status,
    // [51:43] entry_count, [60:52] unique_count, [63:61] zero
    output logic [63:0]                    m_tdata,
    // Resolution register write.
    input  logic                           cfg_wr_en,
    input  logic [stni_pkg::RES_W-1:0]     cfg_wr_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int NCHUNK = (DEPTH + stni_pkg::SCAN_LANES - 1) / stni_pkg::SCAN_LANES;
    localparam int SCAN_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int OW     = stni_pkg::OUT_CNT_W;
    localparam int LANES  = stni_pkg::SCAN_LANES;

    stni_pkg::state_t state_reg, state_next;

    logic [stni_pkg::KIND_W-1:0] req_kind_reg;
    logic [stni_pkg::VAL_W-1:0]  req_value_reg;
    logic [stni_pkg::RES_W-1:0]  resolution_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic [stni_pkg::STAT_W-1:0] stat_reg;
    logic [SCAN_W-1:0]           scan_cnt_reg;
    logic [CNT_W-1:0]            cnt_lt_reg, cnt_lt_next;
    logic [CNT_W-1:0]            cnt_u_reg, cnt_u_next;
    logic [stni_pkg::VAL_W-1:0]  near_reg;
    logic                        left_reg;
    logic                        m_tvalid_reg;
    logic [63:0]                 m_tdata_reg;

    logic table_full;
    logic scan_last;
    logic out_free;
    logic s_ready;
    logic out_load;
    stni_pkg::cell_ctrl_t ctrl;

    // Cell row wiring.
    logic [stni_pkg::VAL_W-1:0] entry_w [DEPTH];
    logic                       valid_w [DEPTH];
    logic                       lt_w    [DEPTH];
    stni_pkg::cell_res_t        res_w   [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [stni_pkg::VAL_W-1:0] p_entry;
            logic                       p_lt;
            logic                       p_valid;
            logic                       h_left;
            logic                       n_valid;
            stni_pkg::cell_res_t        s_in;

            if (gi == 0) begin : g_head
                // The head cell has no left neighbor: an insert that reaches
                // it always writes the new value there.
                assign p_entry = '0;
                assign p_lt    = 1'b1;
                assign p_valid = 1'b1;
                assign h_left  = 1'b0;
            end else begin : g_body
                assign p_entry = entry_w[gi-1];
                assign p_lt    = lt_w[gi-1];
                assign p_valid = valid_w[gi-1];
                assign h_left  = 1'b1;
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign n_valid = 1'b0;
            end else begin : g_mid
                assign n_valid = valid_w[gi+1];
            end

            if (gi + LANES < DEPTH) begin : g_shift
                assign s_in = res_w[gi+LANES];
            end else begin : g_shift_end
                assign s_in = '0;
            end

            stni_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .req_value  (req_value_reg),
                .resolution (resolution_reg),
                .prev_entry (p_entry),
                .prev_lt    (p_lt),
                .prev_valid (p_valid),
                .has_left   (h_left),
                .next_valid (n_valid),
                .shift_in   (s_in),
                .entry      (entry_w[gi]),
                .valid      (valid_w[gi]),
                .lt         (lt_w[gi]),
                .res        (res_w[gi])
            );
        end
    endgenerate

    // The lowest LANES cells form the scan window.
    stni_pkg::cell_res_t view [LANES];

    genvar gk;
    generate
        for (gk = 0; gk < LANES; gk++) begin : g_view
            if (gk < DEPTH) begin : g_real
                assign view[gk] = res_w[gk];
            end else begin : g_pad
                assign view[gk] = '0;
            end
        end
    endgenerate

    logic [LANES-1:0]                lt_bits;
    logic [LANES-1:0]                u_bits;
    logic [stni_pkg::VAL_W-1:0]      sel_val;
    logic                            sel_left;
    logic [stni_pkg::POP_W-1:0]      pop_lt;
    logic [stni_pkg::POP_W-1:0]      pop_u;
    logic [CNT_W+stni_pkg::POP_W-1:0] sum_lt;
    logic [CNT_W+stni_pkg::POP_W-1:0] sum_u;

    always_comb begin
        sel_val  = '0;
        sel_left = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            lt_bits[k] = view[k].lt;
            u_bits[k]  = view[k].uniq;
            sel_val    = sel_val | (view[k].sel ? view[k].val : '0);
            sel_left   = sel_left | (view[k].sel & view[k].left);
        end
        pop_lt = stni_pkg::popcount(lt_bits);
        pop_u  = stni_pkg::popcount(u_bits);
        sum_lt = {{stni_pkg::POP_W{1'b0}}, cnt_lt_reg} + {{CNT_W{1'b0}}, pop_lt};
        sum_u  = {{stni_pkg::POP_W{1'b0}}, cnt_u_reg} + {{CNT_W{1'b0}}, pop_u};
        cnt_lt_next = sum_lt[CNT_W-1:0];
        cnt_u_next  = sum_u[CNT_W-1:0];
    end

    assign table_full = (fill_reg == CNT_W'(DEPTH));
    assign scan_last  = (scan_cnt_reg == SCAN_W'(NCHUNK - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stni_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stni_pkg::ST_EVAL;
                end
            end
            stni_pkg::ST_EVAL: begin
                state_next = stni_pkg::ST_SCAN;
            end
            stni_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = stni_pkg::ST_DONE;
                end
            end
            stni_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = stni_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stni_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready     = 1'b0;
        ctrl.eval   = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.ins_we = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            stni_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            stni_pkg::ST_EVAL: begin
                ctrl.eval   = 1'b1;
                ctrl.ins_we = (req_kind_reg == stni_pkg::KIND_INSERT) && !table_full;
            end
            stni_pkg::ST_SCAN: begin
                ctrl.shift = 1'b1;
            end
            stni_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= stni_pkg::ST_IDLE;
            fill_reg       <= '0;
            resolution_reg <= stni_pkg::RES_W'(1);
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.ins_we) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cfg_wr_en) begin
                resolution_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result beat fields, narrowed to the port widths.
    logic [CNT_W-1:0]           pos_find;
    logic [CNT_W+OW-1:0]        pos_ins_ext;
    logic [CNT_W+OW-1:0]        pos_find_ext;
    logic [CNT_W+OW-1:0]        fill_ext;
    logic [CNT_W+OW-1:0]        uniq_ext;
    logic [OW-1:0]              out_pos;
    logic [stni_pkg::VAL_W-1:0] out_near;
    logic [OW-1:0]              out_uniq;

    always_comb begin
        pos_find     = cnt_lt_reg - {{(CNT_W-1){1'b0}}, left_reg};
        pos_ins_ext  = {{OW{1'b0}}, cnt_lt_reg};
        pos_find_ext = {{OW{1'b0}}, pos_find};
        fill_ext     = {{OW{1'b0}}, fill_reg};
        uniq_ext     = {{OW{1'b0}}, cnt_u_reg};
        out_pos      = '0;
        out_near     = '0;
        out_uniq     = '0;
        case (req_kind_reg)
            stni_pkg::KIND_INSERT: begin
                out_pos = pos_ins_ext[OW-1:0];
            end
            stni_pkg::KIND_FIND: begin
                if (stat_reg == stni_pkg::STAT_OK) begin
                    out_pos  = pos_find_ext[OW-1:0];
                    out_near = near_reg;
                end
            end
            stni_pkg::KIND_COUNT: begin
                out_uniq = uniq_ext[OW-1:0];
            end
            default: begin
                out_pos = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_tvalid) begin
            req_kind_reg  <= s_tuser;
            req_value_reg <= s_tdata;
        end
        if (ctrl.eval) begin
            scan_cnt_reg <= '0;
            cnt_lt_reg   <= '0;
            cnt_u_reg    <= '0;
            near_reg     <= '0;
            left_reg     <= 1'b0;
            if ((req_kind_reg == stni_pkg::KIND_INSERT) && table_full) begin
                stat_reg <= stni_pkg::STAT_FULL;
            end else if ((req_kind_reg == stni_pkg::KIND_FIND) && (fill_reg == '0)) begin
                stat_reg <= stni_pkg::STAT_EMPTY;
            end else begin
                stat_reg <= stni_pkg::STAT_OK;
            end
        end else if (ctrl.shift) begin
            scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
            cnt_lt_reg   <= cnt_lt_next;
            cnt_u_reg    <= cnt_u_next;
            near_reg     <= near_reg | sel_val;
            left_reg     <= left_reg | sel_left;
        end
        if (out_load) begin
            m_tdata_reg <= {3'b000, out_uniq, fill_ext[OW-1:0], stat_reg, out_near, out_pos};
        end
    end

    assign s_tready = s_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/stni_checker.sv
module stni_checker #(
    parameter int DEPTH = stni_pkg::DEPTH_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    localparam logic [8:0] DEPTH_LOW = 9'(DEPTH);
    localparam logic       WIDE      = (DEPTH > 256);

    logic [1:0] status;
    logic [8:0] entry_count;

    assign status      = m_tdata[42:41];
    assign entry_count = m_tdata[51:43];

    // A result beat that is not taken stays on the port unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A dropped insert is only reported when the table holds DEPTH entries.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == stni_pkg::STAT_FULL) |-> entry_count == DEPTH_LOW)
        else $error("full status with table not full");

    // An empty search reports an empty table and a zero value.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == stni_pkg::STAT_EMPTY) |->
            (entry_count == 9'd0) && (m_tdata[40:9] == 32'd0) && (m_tdata[8:0] == 9'd0))
        else $error("empty status with entries or a value");

    // The fill never exceeds the table depth.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> WIDE || (entry_count <= DEPTH_LOW))
        else $error("entry count above depth");

endmodule

bind sorted_table_nearest_insert_core stni_checker #(.DEPTH(DEPTH)) u_stni_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/stni_result_checker.sv
`timescale 1ns / 100ps
module stni_result_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [31:0]                  s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [63:0]                  m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [stni_pkg::RES_W-1:0]   cfg_wr_data,
    input  logic                         end_of_run,
    output int                           fail_count
);

    localparam int TABLE_DEPTH = stni_pkg::DEPTH_DEF;
    localparam int CNT_BITS    = stni_pkg::OUT_CNT_W;
    localparam int VAL_BITS    = stni_pkg::VAL_W;
    localparam int RES_BITS    = stni_pkg::RES_W;

    // Mirrors the m_tdata layout; the first member lands in the top bits.
    typedef struct packed {
        logic [2:0]                  pad;
        logic [CNT_BITS-1:0]         groups;
        logic [CNT_BITS-1:0]         entries;
        logic [stni_pkg::STAT_W-1:0] status;
        logic [VAL_BITS-1:0]         nearest;
        logic [CNT_BITS-1:0]         position;
    } table_result_t;

    logic [VAL_BITS-1:0] distances [TABLE_DEPTH];
    int unsigned         fill;
    logic [RES_BITS-1:0] resolution;
    table_result_t       expected_results [$];
    int                  results_checked;
    int                  mismatches;
    int                  missing;

    assign fail_count = mismatches + missing;

    function automatic int unsigned first_not_below(input logic [VAL_BITS-1:0] v);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (distances[mid] < v) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one request to the shadow table and returns the beat it must produce.
    function automatic table_result_t apply_request(input logic [stni_pkg::KIND_W-1:0] kind,
                                                    input logic [VAL_BITS-1:0] v);
        table_result_t r;
        int unsigned   idx;
        int unsigned   groups;
        logic          take_left;
        r = '0;
        case (kind)
            stni_pkg::KIND_INSERT: begin
                idx = first_not_below(v);
                r.position = CNT_BITS'(idx);
                if (fill >= TABLE_DEPTH) begin
                    r.status = stni_pkg::STAT_FULL;
                end else begin
                    for (int i = fill; i > idx; i--) begin
                        distances[i] = distances[i - 1];
                    end
                    distances[idx] = v;
                    fill++;
                end
            end
            stni_pkg::KIND_FIND: begin
                if (fill == 0) begin
                    r.status = stni_pkg::STAT_EMPTY;
                end else begin
                    idx = first_not_below(v);
                    if (idx == fill) begin
                        take_left = 1'b1;
                    end else if (idx == 0) begin
                        take_left = 1'b0;
                    end else begin
                        // A tie keeps the upper neighbor.
                        take_left = (v - distances[idx - 1]) < (distances[idx] - v);
                    end
                    if (take_left) begin
                        idx--;
                    end
                    r.position = CNT_BITS'(idx);
                    r.nearest  = distances[idx];
                end
            end
            stni_pkg::KIND_COUNT: begin
                groups = 0;
                if (fill > 0) begin
                    groups = 1;
                    for (int i = 1; i < fill; i++) begin
                        if (distances[i] - distances[i - 1] > VAL_BITS'(resolution)) begin
                            groups++;
                        end
                    end
                end
                r.groups = CNT_BITS'(groups);
            end
            default: begin
            end
        endcase
        r.entries = CNT_BITS'(fill);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        table_result_t got;
        table_result_t want;
        if (!aresetn) begin
            fill       = 0;
            resolution = RES_BITS'(1);
            mismatches = 0;
            results_checked = 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                resolution = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                got = table_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat %h", m_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.position !== want.position || got.nearest !== want.nearest ||
                        got.status !== want.status || got.entries !== want.entries ||
                        got.groups !== want.groups || got.pad !== want.pad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected pos=%0d near=%h st=%0d ent=%0d grp=%0d pad=%0d",
                                     results_checked, want.position, want.nearest, want.status,
                                     want.entries, want.groups, want.pad);
                            $display("result %0d:   actual pos=%0d near=%h st=%0d ent=%0d grp=%0d pad=%0d",
                                     results_checked, got.position, got.nearest, got.status,
                                     got.entries, got.groups, got.pad);
                        end
                    end
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata);
                expected_results = {expected_results, want};
            end
        end
    end

    always @(posedge end_of_run) begin
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            missing = expected_results.size();
        end
    end

endmodule

// File: test/sorted_table_nearest_insert_core_tb.sv
`timescale 1ns / 100ps
module sorted_table_nearest_insert_core_tb;

    localparam int KIND_BITS = stni_pkg::KIND_W;
    localparam int VAL_BITS  = stni_pkg::VAL_W;
    localparam int RES_BITS  = stni_pkg::RES_W;

    // The fourth kind code has no meaning; the block must answer it without
    // touching the table.
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    // Inserts on this grid, probed at the midpoints, give exact distance ties
    // whenever two neighboring grid points are both in the table.
    localparam logic [VAL_BITS-1:0] GRID_BASE = 32'h0050_0000;
    localparam logic [VAL_BITS-1:0] GRID_STEP = 32'h0000_0200;

    // Four in ten random inserts fall into a dense cluster so that the gaps between
    // neighbors straddle the resolution settings used below.
    localparam int unsigned CLUSTER_TOP = 32'h0013_FFFF;

    localparam int SEGMENTS      = 9;
    localparam int SEGMENT_ITEMS = 128;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata     = '0;    // [31:0] value
    logic [1:0]           s_tuser     = '0;    // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // [8:0] position, [40:9] nearest_value, [42:41] status,
    // [51:43] entry_count, [60:52] unique_count, [63:61] zero
    logic [63:0]          m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [RES_BITS-1:0]  cfg_wr_data = '0;
    logic                 end_of_run  = 1'b0;
    int                   fail_count;

    // Idle percentages for the two sides. They are set per segment of the run and change every third segment.
    int                   send_idle_pct = 34;
    int                   recv_idle_pct = 63;

    // Beats handed to the block and result beats taken back, used to find out
    // when the block has nothing left in flight.
    int                   beats_sent    = 0;
    int                   results_taken = 0;

    // Every value offered for insertion, dropped inserts included, so that later
    // probes can mostly aim at entries that really are in the table.
    logic [VAL_BITS-1:0]  inserted [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_table_nearest_insert_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    stni_result_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .end_of_run  (end_of_run),
        .fail_count  (fail_count)
    );

    // The receiver stalls cycle by cycle. With the percentage at zero it is
    // always ready.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_taken++;
        end
    end

    // Offers one request beat and returns at the edge that takes it. Valid is
    // left high afterwards so that back-to-back beats never drop it; a gap is
    // inserted beforehand at the sender's idle rate, long enough to land on any
    // phase of the block's multi-cycle request.
    task automatic push_request(input logic [KIND_BITS-1:0] kind,
                                input logic [VAL_BITS-1:0] v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (kind == stni_pkg::KIND_INSERT) begin
            inserted = {inserted, v};
        end
    endtask

    // Drops valid and waits until every request has produced its beat. Each
    // request yields exactly one beat, so the block is idle after that; the
    // short pause only adds margin.
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (results_taken != beats_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_resolution(input logic [RES_BITS-1:0] r);
        await_results();
        cfg_wr_data <= r;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                   roll;
        int                   shape;
        logic [KIND_BITS-1:0] kind;
        logic [VAL_BITS-1:0]  value;
        logic [RES_BITS-1:0]  res_plan [SEGMENTS];

        res_plan = '{16'h0000, 16'hFFFF, 16'h0200, 16'h0001, 16'h01FF,
                     16'h0000, 16'h1000, 16'h0000, 16'hFFFF};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. An empty table first: find reports empty, count gives
        // zero groups, and the unused kind changes nothing.
        push_request(stni_pkg::KIND_FIND, 32'h0000_0000);
        push_request(stni_pkg::KIND_COUNT, 32'hFFFF_FFFF);
        push_request(KIND_UNUSED, 32'h1234_5678);

        // Extremes of the value range, a duplicate that must go in front of its
        // twin, and two small values with an even gap.
        push_request(stni_pkg::KIND_INSERT, 32'h8000_0000);
        push_request(stni_pkg::KIND_INSERT, 32'h0000_0000);
        push_request(stni_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        push_request(stni_pkg::KIND_INSERT, 32'h8000_0000);
        push_request(stni_pkg::KIND_INSERT, 32'd100);
        push_request(stni_pkg::KIND_INSERT, 32'd200);

        // The midpoint of 100 and 200 is an exact tie and must pick 200. The
        // others probe both ends of the table and the interior.
        push_request(stni_pkg::KIND_FIND, 32'd150);
        push_request(stni_pkg::KIND_FIND, 32'd149);
        push_request(stni_pkg::KIND_FIND, 32'hFFFF_FFFF);
        push_request(stni_pkg::KIND_FIND, 32'h0000_0000);
        push_request(stni_pkg::KIND_FIND, 32'h7FFF_FFFF);
        push_request(stni_pkg::KIND_FIND, 32'hC000_0000);

        // Group count under the reset resolution, then the unused kind with six
        // entries in the table behind it.
        push_request(stni_pkg::KIND_COUNT, 32'h0000_0000);
        push_request(KIND_UNUSED, 32'hFFFF_FFFF);

        // The same table counted under zero, the widest and an exact-gap
        // resolution, where a gap equal to the resolution must not split.
        write_resolution(16'h0000);
        push_request(stni_pkg::KIND_COUNT, 32'h0000_0000);
        write_resolution(16'hFFFF);
        push_request(stni_pkg::KIND_COUNT, 32'h0000_0000);
        write_resolution(16'd100);
        push_request(stni_pkg::KIND_COUNT, 32'h0000_0000);

        // Random part. The table only ever grows, so it fills up part way
        // through and the later inserts exercise the dropped-insert path.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_resolution((seg == 5) ? RES_BITS'($urandom) : res_plan[seg]);

            repeat (SEGMENT_ITEMS) begin
                roll  = $urandom_range(0, 99);
                shape = $urandom_range(0, 9);
                if (roll < 36) begin
                    kind = stni_pkg::KIND_INSERT;
                end else if (roll < 76) begin
                    kind = stni_pkg::KIND_FIND;
                end else if (roll < 94) begin
                    kind = stni_pkg::KIND_COUNT;
                end else begin
                    kind = KIND_UNUSED;
                end

                value = $urandom;
                if (kind == stni_pkg::KIND_INSERT) begin
                    if (shape >= 1 && shape <= 4) begin
                        value = $urandom_range(0, CLUSTER_TOP);
                    end else if (shape >= 5 && shape <= 7) begin
                        value = GRID_BASE + GRID_STEP * $urandom_range(0, 63);
                    end else if (shape >= 8) begin
                        value = inserted[$urandom_range(0, inserted.size() - 1)]
                              + $urandom_range(0, 3);
                    end
                end else if (kind == stni_pkg::KIND_FIND) begin
                    if (shape >= 2 && shape <= 4) begin
                        value = GRID_BASE + GRID_STEP * $urandom_range(0, 63) + GRID_STEP / 2;
                    end else if (shape == 5 || shape == 6) begin
                        value = inserted[$urandom_range(0, inserted.size() - 1)];
                    end else if (shape == 7) begin
                        value = inserted[$urandom_range(0, inserted.size() - 1)]
                              - 2 + $urandom_range(0, 4);
                    end else if (shape >= 8) begin
                        value = $urandom_range(0, CLUSTER_TOP);
                    end
                end
                push_request(kind, value);
            end
        end

        // All stimulus is in. Wait for the last beats, then keep the clock running
        // so that any stray beat would still be seen.
        await_results();
        repeat (16) @(posedge aclk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Safety net: ends a run that never finishes.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
